/* hdl/llt_pkg.sv */
// ----------------------------------------------------------------------------
// llt_pkg
// Types and constants shared by the least loaded task dispatcher modules.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int unsigned MaxProcsDef = 16;
  localparam int unsigned MaxTasksDef = 1024;

  // Token fields are sized for the widest legal parameter values.
  localparam int unsigned IdxFieldW = 6;   // up to 64 processors
  localparam int unsigned CntFieldW = 17;  // up to 65536 tasks
  localparam int unsigned LoadW     = 32;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned CfgW      = 5;

  localparam logic [CfgW-1:0] ActiveProcsRst = 5'd16;

  typedef struct packed {
    logic             new_batch;
    logic [TimeW-1:0] task_time;
  } llt_in_t;

  typedef struct packed {
    logic [3:0]       proc_index;
    logic [9:0]       slot;
    logic [10:0]      task_number;
    logic [LoadW-1:0] new_load;
    logic             saturated;
  } llt_out_t;

  // Running minimum that walks down the cell chain.
  typedef struct packed {
    logic                 valid;
    logic                 have;
    logic [IdxFieldW-1:0] idx;
    logic [LoadW-1:0]     load;
    logic [CntFieldW-1:0] cnt;
  } llt_tok_t;

  // Update sent back to the winning cell.
  typedef struct packed {
    logic                 valid;
    logic [IdxFieldW-1:0] idx;
    logic [LoadW-1:0]     load;
    logic                 inc;
  } llt_wr_t;

endpackage

/* hdl/llt_cell.sv */
// ----------------------------------------------------------------------------
// llt_cell
// One processor slot: holds its load and slot count, and compares its load
// against the running minimum passing through, one hop per cycle.
// ----------------------------------------------------------------------------
module llt_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CNT_W    = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              active_i,
  input  llt_pkg::llt_wr_t  wr_i,
  input  llt_pkg::llt_tok_t tok_i,
  output llt_pkg::llt_tok_t tok_o
);

  logic [llt_pkg::LoadW-1:0] load_q, load_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  llt_pkg::llt_tok_t         tok_q, tok_d;
  logic                      hit;
  logic                      take;

  assign hit  = wr_i.valid && (wr_i.idx == llt_pkg::IdxFieldW'(CELL_IDX));
  assign take = tok_i.valid && active_i && (!tok_i.have || (load_q < tok_i.load));

  always_comb begin
    load_d = load_q;
    cnt_d  = cnt_q;
    if (clear_i) begin
      load_d = '0;
      cnt_d  = '0;
    end else if (hit) begin
      load_d = wr_i.load;
      if (wr_i.inc) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.have = 1'b1;
      tok_d.idx  = llt_pkg::IdxFieldW'(CELL_IDX);
      tok_d.load = load_q;
      tok_d.cnt  = llt_pkg::CntFieldW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      cnt_q  <= '0;
      tok_q  <= '0;
    end else begin
      load_q <= load_d;
      cnt_q  <= cnt_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hdl/least_loaded_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher
// Flow: an accepted task is registered, its token enters cell 0 and walks the
//   cell chain one processor per cycle, and the result is registered as done_o rises.
// One task at a time: busy holds until the token leaves the chain, so a new task
//   is taken only after that. Reset clears all loads, slot counts and the task
//   counter; active_procs returns to 16. The receiver cannot stall; done_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher #(
  parameter int unsigned MAX_PROCS = llt_pkg::MaxProcsDef,
  parameter int unsigned MAX_TASKS = llt_pkg::MaxTasksDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  llt_pkg::llt_in_t          in_i,
  output logic                      done_o,
  output llt_pkg::llt_out_t         res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [llt_pkg::CfgW-1:0]  cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);

  logic                        busy_q, launch_q, done_q;
  logic [llt_pkg::TimeW-1:0]   time_q;
  logic [CntW-1:0]             task_cnt_q, task_cnt_d;
  logic [llt_pkg::CfgW-1:0]    act_q;
  llt_pkg::llt_out_t           res_q, res_d;
  logic                        accept;
  logic                        clear;
  llt_pkg::llt_tok_t           tok [MAX_PROCS+1];
  llt_pkg::llt_tok_t           tok_exit;
  llt_pkg::llt_wr_t            wr;
  logic [llt_pkg::LoadW:0]     sum;
  logic                        load_sat, slot_sat, task_sat;
  logic [llt_pkg::CntFieldW-1:0] slot_val;
  logic [CntW-1:0]             number;

  assign accept      = start && !busy_q;
  assign clear       = accept && in_i.new_batch;
  assign busy        = busy_q;
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = !busy_q;

  // Fresh token enters cell 0 in the cycle after the task is taken.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch_q;
  end

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    logic active;
    assign active = (i == 0) || ({27'd0, act_q} > 32'(i));

    llt_cell #(
      .CELL_IDX (i),
      .CNT_W    (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (clear),
      .active_i (active),
      .wr_i     (wr),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  assign tok_exit = tok[MAX_PROCS];

  always_comb begin
    sum      = {1'b0, tok_exit.load} + {{(llt_pkg::LoadW + 1 - llt_pkg::TimeW){1'b0}}, time_q};
    load_sat = sum[llt_pkg::LoadW];
    slot_sat = tok_exit.cnt >= llt_pkg::CntFieldW'(MAX_TASKS);
    task_sat = task_cnt_q >= CntW'(MAX_TASKS);
    slot_val = slot_sat ? llt_pkg::CntFieldW'(MAX_TASKS - 1) : tok_exit.cnt;
    number   = task_sat ? CntW'(MAX_TASKS) : task_cnt_q + CntW'(1);

    wr.valid = tok_exit.valid;
    wr.idx   = tok_exit.idx;
    wr.load  = load_sat ? '1 : sum[llt_pkg::LoadW-1:0];
    wr.inc   = !slot_sat;

    res_d.proc_index  = tok_exit.idx[3:0];
    res_d.slot        = slot_val[9:0];
    res_d.task_number = 11'(number);
    res_d.new_load    = wr.load;
    res_d.saturated   = load_sat || slot_sat || task_sat;

    task_cnt_d = task_cnt_q;
    if (clear) begin
      task_cnt_d = '0;
    end else if (tok_exit.valid && !task_sat) begin
      task_cnt_d = number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      launch_q   <= 1'b0;
      done_q     <= 1'b0;
      task_cnt_q <= '0;
      act_q      <= llt_pkg::ActiveProcsRst;
    end else begin
      launch_q   <= accept;
      done_q     <= tok_exit.valid;
      task_cnt_q <= task_cnt_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tok_exit.valid) begin
        busy_q <= 1'b0;
      end
      if (cfg_valid_i && !busy_q) begin
        act_q <= cfg_data_i;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_q <= in_i.task_time;
    end
    if (tok_exit.valid) begin
      res_q <= res_d;
    end
  end

endmodule

/* hdl/llt_checker.sv */
// ----------------------------------------------------------------------------
// llt_checker
// Port-level checks on the dispatcher's start/busy/done sequencing.
// ----------------------------------------------------------------------------
module llt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input llt_pkg::llt_out_t res_o
);

  // A taken task keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // A result only appears once the block has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Busy drops only when the result is delivered.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without result");

  // One result per task: the strobe is never held.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // Task numbers are 1-based.
  a_task_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.task_number != 11'd0)
    else $error("task number zero");

endmodule

bind least_loaded_task_dispatcher llt_checker u_llt_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

/* verif/llt_dispatch_checker.sv */
// ----------------------------------------------------------------------------
// llt_dispatch_checker
// Watches the task, result and configuration channels of the least loaded
// task dispatcher. Keeps its own copy of the processor loads, slot counts,
// task counter and active processor count, predicts the assignment for each
// accepted task and compares every result strobe field by field.
// ----------------------------------------------------------------------------
module llt_dispatch_checker
  import llt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  llt_in_t         task_i,
  input  logic            done_i,
  input  llt_out_t        res_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int              pending_o,
  output int              fail_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LoadW-1:0] load_mirror [MaxProcsDef];
  logic [10:0]      slot_count_mirror [MaxProcsDef];
  logic [10:0]      batch_task_count;
  logic [CfgW-1:0]  active_setting;
  llt_out_t         expected_assignments_q [$];
  int               mismatches;

  assign pending_o  = expected_assignments_q.size();
  assign fail_cnt_o = mismatches;

  function automatic void clear_batch_mirror();
    for (int p = 0; p < MaxProcsDef; p++) begin
      load_mirror[p]       = '0;
      slot_count_mirror[p] = '0;
    end
    batch_task_count = '0;
  endfunction

  // Greedy pick: smallest load among the active processors, lowest index on tie.
  function automatic llt_out_t assign_to_least_loaded(llt_in_t item);
    int unsigned      n_procs;
    int unsigned      best;
    logic [LoadW:0]   sum;
    logic [10:0]      slot;
    logic [10:0]      number;
    logic             sat;
    llt_out_t         res;
    if (item.new_batch) clear_batch_mirror();
    n_procs = 32'(active_setting);
    if (n_procs < 1) n_procs = 1;
    if (n_procs > MaxProcsDef) n_procs = MaxProcsDef;
    best = 0;
    for (int p = 1; p < n_procs; p++) begin
      if (load_mirror[p] < load_mirror[best]) best = p;
    end
    sat = 1'b0;
    sum = {1'b0, load_mirror[best]} + {{(LoadW + 1 - TimeW){1'b0}}, item.task_time};
    if (sum[LoadW]) begin
      sum = {1'b0, {LoadW{1'b1}}};
      sat = 1'b1;
    end
    load_mirror[best] = sum[LoadW-1:0];
    slot = slot_count_mirror[best];
    if (slot >= MaxTasksDef) begin
      slot = 11'(MaxTasksDef - 1);
      sat  = 1'b1;
    end else begin
      slot_count_mirror[best] = slot + 1'b1;
    end
    if (batch_task_count >= MaxTasksDef) begin
      number = 11'(MaxTasksDef);
      sat    = 1'b1;
    end else begin
      batch_task_count = batch_task_count + 1'b1;
      number           = batch_task_count;
    end
    res.proc_index  = best[3:0];
    res.slot        = slot[9:0];
    res.task_number = number;
    res.new_load    = sum[LoadW-1:0];
    res.saturated   = sat;
    return res;
  endfunction

  function automatic void compare_field(string fname, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    llt_out_t want;
    if (!rst_ni) begin
      clear_batch_mirror();
      active_setting = ActiveProcsRst;
      expected_assignments_q.delete();
      mismatches = 0;
    end else begin
      if (done_i) begin
        if (expected_assignments_q.size() == 0) begin
          $display("%0t: result with no task pending, expected none, actual %p",
                   $time, res_i);
          mismatches++;
        end else begin
          want = expected_assignments_q.pop_front();
          compare_field("proc_index", want.proc_index, res_i.proc_index);
          compare_field("slot", want.slot, res_i.slot);
          compare_field("task_number", want.task_number, res_i.task_number);
          compare_field("new_load", want.new_load, res_i.new_load);
          compare_field("saturated", want.saturated, res_i.saturated);
        end
      end
      if (cfg_valid_i && cfg_ready_i) active_setting = cfg_data_i;
      if (start_i && !busy_i)
        expected_assignments_q.push_back(assign_to_least_loaded(task_i));
    end
  end

endmodule

/* verif/tb_least_loaded_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// tb_least_loaded_task_dispatcher
// Drives tasks and active processor settings into the dispatcher: a directed
// opening, a long single-processor run that drives slot counts and the task
// counter into saturation, then random tasks under three idling patterns.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_least_loaded_task_dispatcher;
  import llt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles   = MaxProcsDef + 8;
  localparam int WatchdogLimit = 2000;
  localparam int SatRunTasks   = 1026;
  localparam int SegmentTasks  = 12;

  logic            clk_i;
  logic            rst_ni    = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  llt_in_t         task_item = '0;
  logic            done;
  llt_out_t        res;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_data  = '0;
  int              pending;
  int              fail_cnt;

  least_loaded_task_dispatcher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (task_item),
    .done_o      (done),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  llt_dispatch_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .task_i      (task_item),
    .done_i      (done),
    .res_i       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fail_cnt_o  (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sample handshakes at the falling edge, then move to the next rising edge.
  task automatic tick(output bit item_took, output bit cfg_took);
    @(negedge clk_i);
    item_took = start && !busy;
    cfg_took  = cfg_valid && cfg_ready;
    @(posedge clk_i);
  endtask

  task automatic issue_task(input llt_in_t item, input int idle_pct);
    bit took, ctook;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      tick(took, ctook);
    end
    start     <= 1'b1;
    task_item <= item;
    do tick(took, ctook); while (!took);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [CfgW-1:0] value);
    bit took, ctook;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do tick(took, ctook); while (!ctook);
    cfg_valid <= 1'b0;
  endtask

  function automatic llt_in_t make_task(logic nb, logic [TimeW-1:0] dur);
    llt_in_t item;
    item.new_batch = nb;
    item.task_time = dur;
    return item;
  endfunction

  // Mix full-range durations with tiny ones (to force ties) and the extremes.
  function automatic llt_in_t random_task();
    logic [TimeW-1:0] dur;
    case ($urandom_range(9))
      0:       dur = '0;
      1:       dur = '1;
      2, 3:    dur = TimeW'($urandom_range(15));
      default: dur = TimeW'($urandom);
    endcase
    return make_task($urandom_range(39) == 0, dur);
  endfunction

  initial begin
    int unsigned setting_list [9];
    int unsigned seg;
    int unsigned idle_list [3];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: all sixteen processors, ties go to the lowest index.
    issue_task(make_task(1'b0, 16'h0000), 0);
    issue_task(make_task(1'b0, 16'h0000), 0);
    issue_task(make_task(1'b0, 16'hFFFF), 0);
    issue_task(make_task(1'b0, 16'h5555), 0);
    issue_task(make_task(1'b0, 16'hAAAA), 0);
    issue_task(make_task(1'b0, 16'h0001), 0);
    issue_task(make_task(1'b1, 16'h1234), 0);
    issue_task(make_task(1'b0, 16'h0002), 0);
    // Zero active processors behaves as one.
    write_active(5'd0);
    issue_task(make_task(1'b0, 16'h0007), 0);
    issue_task(make_task(1'b0, 16'h0009), 0);
    // Counts above the processor limit clamp to it.
    write_active(5'd31);
    issue_task(make_task(1'b0, 16'h0003), 0);
    issue_task(make_task(1'b0, 16'h0000), 0);
    write_active(5'd1);
    issue_task(make_task(1'b1, 16'h0005), 0);
    // Inactive processors keep their loads across a shrink and regrow.
    write_active(5'd5);
    repeat (3) issue_task(make_task(1'b0, 16'h0064), 0);
    write_active(5'd16);
    issue_task(make_task(1'b0, 16'h0001), 0);

    // One processor, longest tasks: the slot count and the task counter
    // both saturate.
    write_active(5'd1);
    issue_task(make_task(1'b1, 16'hFFFF), 0);
    repeat (SatRunTasks - 1) issue_task(make_task(1'b0, 16'hFFFF), 0);
    write_active(5'd16);
    issue_task(make_task(1'b1, 16'h0000), 0);

    idle_list    = '{34, 82, 0};
    setting_list = '{16, 1, 31, 0, 2, 15, 0, 0, 0};
    for (int s = 6; s < 9; s++) setting_list[s] = $urandom_range(31);
    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 3; k++) begin
        seg = ph * 3 + k;
        write_active(CfgW'(setting_list[seg]));
        repeat (SegmentTasks) issue_task(random_task(), idle_list[ph]);
      end
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("least_loaded_task_dispatcher test passed");
    end else begin
      $display("least_loaded_task_dispatcher test failed");
    end
    $finish;
  end

  // Abort when no item, result or setting has moved for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(negedge clk_i);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("least_loaded_task_dispatcher test failed");
    $finish;
  end

endmodule
